// File: sv/trq_pkg.sv
// ============================================================================
// trq_pkg
// Shared types and constants for the task ready queue.
// ============================================================================
package trq_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ID_W   = 8;
    localparam int TIME_W = 32;
    localparam int OP_W   = 3;
    localparam int ST_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH       = 3'd0,
        OP_INSERT     = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_READY  = 3'd3,
        OP_COUNT_DUE  = 3'd4,
        OP_SET_READY  = 3'd5
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_WALK,
        S_LINK,
        S_FRONT
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic load_in;
        logic alloc;
        logic set_full;
        logic set_empty;
        logic pop_head;
        logic step;
        logic count_inc;
        logic insert_here;
        logic unlink_here;
        logic set_here;
        logic append;
        logic sel_head;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        op_t  op;
        logic full;
        logic empty;
        logic walk_done;
        logic hit;
        logic out_free;
    } stat_t;

endpackage

// File: sv/trq_if.sv
// ============================================================================
// trq_if
// Request and response channels of the task ready queue.
// ============================================================================
interface trq_req_if;
    logic                        valid;
    logic                        ready;
    logic [trq_pkg::OP_W-1:0]    op;
    logic [trq_pkg::ID_W-1:0]    task_id;
    logic                        task_ready;
    logic [trq_pkg::TIME_W-1:0]  start_time;
    logic [trq_pkg::TIME_W-1:0]  elapsed_time;

    modport source (output valid, output op, output task_id, output task_ready,
                    output start_time, output elapsed_time, input ready);
    modport sink   (input valid, input op, input task_id, input task_ready,
                    input start_time, input elapsed_time, output ready);
endinterface

interface trq_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [trq_pkg::ID_W-1:0]    popped_id;
    logic [trq_pkg::ST_W-1:0]    status;
    logic [trq_pkg::CNT_W-1:0]   due_count;
    logic [trq_pkg::CNT_W-1:0]   queue_length;
    logic [trq_pkg::ID_W-1:0]    front_id;
    logic                        front_valid;

    modport source (output valid, output popped_id, output status, output due_count,
                    output queue_length, output front_id, output front_valid,
                    input ready);
    modport sink   (input valid, input popped_id, input status, input due_count,
                    input queue_length, input front_id, input front_valid,
                    output ready);
endinterface

// File: sv/task_ready_queue_unit.sv
// ============================================================================
// task_ready_queue_unit
// Linked-list task queue with push, ordered insert, front pop, ready pop, due count, set ready and peek.
// ============================================================================
//  channel  dir  beat carries
//  req      in   op, task_id, task_ready, start_time, elapsed_time
//  rsp      out  popped_id, status, due_count, queue_length, front_id, front_valid
//
//  One request at a time: accept, decode, then a list walk of one entry per
//  cycle (up to DEPTH), an optional link step and a peek step that waits
//  for the result register to be free.
//  The result register frees the request side while a response beat waits.
//  rst_n clears the list pointers, the count and the slot in-use bits.
module task_ready_queue_unit (
    input  logic      clk,
    input  logic      rst_n,
    trq_req_if.sink   req,
    trq_rsp_if.source rsp
);
    import trq_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    trq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    trq_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .stat  (stat)
    );

endmodule

// File: sv/trq_ctrl.sv
// ============================================================================
// trq_ctrl
// Sequencer: decodes the operation and steps the list walk.
// ============================================================================
module trq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  trq_pkg::stat_t stat,
    output trq_pkg::cmd_t  cmd
);
    import trq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (stat.in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (stat.op)
                    OP_PUSH, OP_INSERT:
                    begin
                        if (stat.full)
                        begin
                            cmd.set_full = 1'b1;
                            state_next   = S_FRONT;
                        end
                        else
                        begin
                            cmd.alloc = 1'b1;
                            if (stat.op == OP_PUSH || stat.empty)
                                state_next = S_LINK;
                            else
                                state_next = S_WALK;
                        end
                    end
                    OP_POP_FRONT:
                    begin
                        if (stat.empty)
                            cmd.set_empty = 1'b1;
                        else
                            cmd.pop_head = 1'b1;
                        state_next = S_FRONT;
                    end
                    OP_POP_READY, OP_SET_READY:
                    begin
                        cmd.set_empty = 1'b1;
                        state_next    = S_WALK;
                    end
                    OP_COUNT_DUE:
                    begin
                        state_next = S_WALK;
                    end
                    default:
                    begin
                        state_next = S_FRONT;
                    end
                endcase
            end
            S_WALK:
            begin
                priority if (stat.walk_done)
                begin
                    state_next = (stat.op == OP_INSERT) ? S_LINK : S_FRONT;
                end
                else if (stat.hit && stat.op != OP_COUNT_DUE)
                begin
                    unique case (stat.op)
                        OP_INSERT:    cmd.insert_here = 1'b1;
                        OP_POP_READY: cmd.unlink_here = 1'b1;
                        OP_SET_READY: cmd.set_here    = 1'b1;
                        default:      cmd.step        = 1'b0;
                    endcase
                    state_next = S_FRONT;
                end
                else
                begin
                    cmd.count_inc = stat.hit;
                    cmd.step      = 1'b1;
                end
            end
            S_LINK:
            begin
                cmd.append = 1'b1;
                state_next = S_FRONT;
            end
            S_FRONT:
            begin
                cmd.sel_head = 1'b1;
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: sv/trq_datapath.sv
// ============================================================================
// trq_datapath
// Entry stores, list pointers, walk cursor and output register.
// ============================================================================
module trq_datapath (
    input  logic           clk,
    input  logic           rst_n,
    trq_req_if.sink        req,
    trq_rsp_if.source      rsp,
    input  trq_pkg::cmd_t  cmd,
    output trq_pkg::stat_t stat
);
    import trq_pkg::*;

    // entry stores, undefined until written
    logic [ID_W-1:0]   ids_reg    [DEPTH];
    logic              rdy_reg    [DEPTH];
    logic [TIME_W-1:0] starts_reg [DEPTH];
    logic [IDX_W-1:0]  links_reg  [DEPTH];

    // latched request
    op_t               op_reg;
    logic [ID_W-1:0]   id_reg;
    logic              rdy_in_reg;
    logic [TIME_W-1:0] start_reg;
    logic [TIME_W-1:0] elapsed_reg;

    // list and walk state
    logic [DEPTH-1:0]  used_reg,    used_next;
    logic [IDX_W-1:0]  head_reg,    head_next;
    logic [IDX_W-1:0]  tail_reg,    tail_next;
    logic [CNT_W-1:0]  count_reg,   count_next;
    logic [IDX_W-1:0]  cur_reg,     cur_next;
    logic [IDX_W-1:0]  prev_reg,    prev_next;
    logic              prev_ok_reg, prev_ok_next;
    logic [CNT_W-1:0]  idx_reg,     idx_next;
    logic [IDX_W-1:0]  slot_reg,    slot_next;
    logic [CNT_W-1:0]  due_reg,     due_next;
    logic [ID_W-1:0]   popped_reg,  popped_next;
    status_t           status_reg,  status_next;

    // result register
    logic              out_valid_reg;
    logic [ID_W-1:0]   out_popped_reg;
    status_t           out_status_reg;
    logic [CNT_W-1:0]  out_due_reg;
    logic [CNT_W-1:0]  out_len_reg;
    logic [ID_W-1:0]   out_front_reg;
    logic              out_fvalid_reg;

    logic [IDX_W-1:0]  rd_addr;
    logic [ID_W-1:0]   rd_id;
    logic              rd_rdy;
    logic [TIME_W-1:0] rd_start;
    logic [IDX_W-1:0]  rd_link;
    logic [IDX_W-1:0]  free_idx;
    logic              hit;

    assign rd_addr  = cmd.sel_head ? head_reg : cur_reg;
    assign rd_id    = ids_reg[rd_addr];
    assign rd_rdy   = rdy_reg[rd_addr];
    assign rd_start = starts_reg[rd_addr];
    assign rd_link  = links_reg[rd_addr];

    always_comb
    begin
        free_idx = '0;
        for (int k = DEPTH - 1; k >= 0; k--)
        begin
            if (!used_reg[k])
                free_idx = IDX_W'(k);
        end
    end

    always_comb
    begin
        unique case (op_reg)
            OP_INSERT:    hit = (start_reg < rd_start);
            OP_POP_READY: hit = rd_rdy;
            OP_COUNT_DUE: hit = (rd_start < elapsed_reg);
            OP_SET_READY: hit = (rd_id == id_reg);
            default:      hit = 1'b0;
        endcase
    end

    assign stat.in_valid  = req.valid;
    assign stat.op        = op_reg;
    assign stat.full      = (count_reg == CNT_W'(DEPTH));
    assign stat.empty     = (count_reg == '0);
    assign stat.walk_done = (idx_reg == count_reg);
    assign stat.hit       = hit;
    assign stat.out_free  = !out_valid_reg || rsp.ready;

    assign req.ready = cmd.in_ready;

    always_comb
    begin
        used_next    = used_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        prev_ok_next = prev_ok_reg;
        idx_next     = idx_reg;
        slot_next    = slot_reg;
        due_next     = due_reg;
        popped_next  = popped_reg;
        status_next  = status_reg;

        if (cmd.load_in)
        begin
            cur_next     = head_reg;
            prev_ok_next = 1'b0;
            idx_next     = '0;
            due_next     = '0;
            popped_next  = '0;
            status_next  = ST_OK;
        end
        if (cmd.set_full)
            status_next = ST_FULL;
        if (cmd.set_empty)
            status_next = ST_EMPTY;
        if (cmd.alloc)
        begin
            used_next[free_idx] = 1'b1;
            slot_next           = free_idx;
        end
        if (cmd.pop_head)
        begin
            popped_next        = rd_id;
            head_next          = rd_link;
            used_next[cur_reg] = 1'b0;
            count_next         = count_reg - CNT_W'(1);
        end
        if (cmd.step)
        begin
            prev_next    = cur_reg;
            prev_ok_next = 1'b1;
            cur_next     = rd_link;
            idx_next     = idx_reg + CNT_W'(1);
        end
        if (cmd.count_inc)
            due_next = due_reg + CNT_W'(1);
        if (cmd.insert_here)
        begin
            if (!prev_ok_reg)
                head_next = slot_reg;
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.unlink_here)
        begin
            popped_next = rd_id;
            if (!prev_ok_reg)
                head_next = rd_link;
            if (cur_reg == tail_reg && prev_ok_reg)
                tail_next = prev_reg;
            used_next[cur_reg] = 1'b0;
            count_next         = count_reg - CNT_W'(1);
            status_next        = ST_OK;
        end
        if (cmd.set_here)
            status_next = ST_OK;
        if (cmd.append)
        begin
            if (count_reg == '0)
                head_next = slot_reg;
            tail_next  = slot_reg;
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            cur_reg       <= '0;
            prev_reg      <= '0;
            prev_ok_reg   <= 1'b0;
            idx_reg       <= '0;
            slot_reg      <= '0;
            due_reg       <= '0;
            popped_reg    <= '0;
            status_reg    <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg    <= used_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            cur_reg     <= cur_next;
            prev_reg    <= prev_next;
            prev_ok_reg <= prev_ok_next;
            idx_reg     <= idx_next;
            slot_reg    <= slot_next;
            due_reg     <= due_next;
            popped_reg  <= popped_next;
            status_reg  <= status_next;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg      <= op_t'(req.op);
            id_reg      <= req.task_id;
            rdy_in_reg  <= req.task_ready;
            start_reg   <= req.start_time;
            elapsed_reg <= req.elapsed_time;
        end
        if (cmd.alloc)
        begin
            ids_reg[free_idx]    <= id_reg;
            rdy_reg[free_idx]    <= rdy_in_reg;
            starts_reg[free_idx] <= start_reg;
            links_reg[free_idx]  <= '0;
        end
        if (cmd.insert_here)
        begin
            links_reg[slot_reg] <= cur_reg;
            if (prev_ok_reg)
                links_reg[prev_reg] <= slot_reg;
        end
        if (cmd.unlink_here && prev_ok_reg)
            links_reg[prev_reg] <= rd_link;
        if (cmd.set_here)
            rdy_reg[cur_reg] <= rdy_in_reg;
        if (cmd.append && count_reg != '0)
            links_reg[tail_reg] <= slot_reg;
        if (cmd.out_load)
        begin
            out_popped_reg <= popped_reg;
            out_status_reg <= status_reg;
            out_due_reg    <= due_reg;
            out_len_reg    <= count_reg;
            out_front_reg  <= (count_reg != '0) ? rd_id : '0;
            out_fvalid_reg <= (count_reg != '0);
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.popped_id    = out_popped_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.due_count    = out_due_reg;
    assign rsp.queue_length = out_len_reg;
    assign rsp.front_id     = out_front_reg;
    assign rsp.front_valid  = out_fvalid_reg;

endmodule
